### hw/rtl/hsl_to_rgb_converter_assert.svh
// ---------------------------------------------------------------------------
// hsl_to_rgb_converter_assert.svh
// Assertion macros shared by the HSL to RGB converter RTL.
// ---------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define HSLC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define HSLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/hslc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslc_pkg
// Widths, fixed-point constants and shared types of the HSL to RGB converter.
// ---------------------------------------------------------------------------
package hslc_pkg;

   // field formats
   localparam int FRAC_BITS     = 12;
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_W         = 24;
   localparam int FIELD_W       = 16;
   localparam int BYTE_W        = 8;

   // fixed-point units
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int SECTOR_LEN = 60 << HUE_FRAC_BITS;
   localparam int FULL_TURN  = 360 << HUE_FRAC_BITS;

   // whole turns added so that every hue becomes non-negative
   localparam int HUE_OFFSET =
      (((1 << (HUE_W - 1)) + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
   localparam int U_W = HUE_W + 1;

   // reciprocal of one turn; the quotient estimate is low by at most one
   localparam int              RECIP_SHIFT = U_W + 10;
   localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / FULL_TURN;
   localparam int              RECIP_W     = $clog2(RECIP + 1);
   localparam int              Q_W         = $clog2((1 << U_W) / FULL_TURN + 1);
   localparam int              HW_W        = $clog2(2 * FULL_TURN);

   // datapath widths
   localparam int T_W  = $clog2(SECTOR_LEN + 1);
   localparam int CL_W = FRAC_BITS + 1;
   localparam int C2_W = 2 * FRAC_BITS + 1;
   localparam int A_W  = 2 * FRAC_BITS + 2;
   localparam int N_W  = 2 * FRAC_BITS + T_W + 2;

   // channel numerators are over 2 * ONE^2 * SECTOR_LEN = 15 * 2^SCALE_SHIFT,
   // so 255 / denominator reduces to 17 / 2^SCALE_SHIFT
   localparam int SCALE_MUL   = 17;
   localparam int SCALE_SHIFT = 2 * FRAC_BITS + HUE_FRAC_BITS + 3;
   localparam int SCALED_W    = N_W + 5;

   // 60-degree hue sectors: which channels carry chroma and secondary
   typedef enum logic [2:0] {
      SEC_RG = 3'd0,
      SEC_GR = 3'd1,
      SEC_GB = 3'd2,
      SEC_BG = 3'd3,
      SEC_BR = 3'd4,
      SEC_RB = 3'd5
   } sector_type;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic s7;
      logic s6;
      logic s5;
      logic s4;
      logic s3;
      logic s2;
      logic s1;
   } pipe_en_type;

endpackage

### hw/rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// An item captured at its accepting edge passes stages s1 to s7 in order and
// is then on rsp_*, where its result waits until it is taken.
// Throughput: one item per cycle; the pipeline is seven register stages
// and a full stage holds only while the stage after it holds.
// Reset clears the valid bit of every stage; payload registers are not reset.
// ---------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts an HSL color with alpha into 8-bit RGBA in a seven-stage pipeline.
// ---------------------------------------------------------------------------
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter
   import hslc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [HUE_W-1:0]    req_hue,
   input  logic [FIELD_W-1:0]  req_saturation,
   input  logic [FIELD_W-1:0]  req_lightness,
   input  logic [FIELD_W-1:0]  req_alpha,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_red,
   output logic [BYTE_W-1:0]   rsp_green,
   output logic [BYTE_W-1:0]   rsp_blue,
   output logic [BYTE_W-1:0]   rsp_opacity
);

   pipe_en_type        adv;
   logic [7:1]         adv_vec;
   logic [7:1]         vld_ff;
   sector_type         sector;
   logic [T_W-1:0]     ramp;
   logic [C2_W-1:0]    chroma;
   logic [A_W-1:0]     offset;
   logic [BYTE_W-1:0]  opacity4;
   logic               acc_in, acc_out;
   logic [3:0]         n_vld;
   logic               no_hs, in_only, full_wait;

   // a stage loads when it is empty or the stage after it moves
   always_comb begin
      adv.s7 = !vld_ff[7] || !rsp_stall;
      adv.s6 = !vld_ff[6] || adv.s7;
      adv.s5 = !vld_ff[5] || adv.s6;
      adv.s4 = !vld_ff[4] || adv.s5;
      adv.s3 = !vld_ff[3] || adv.s4;
      adv.s2 = !vld_ff[2] || adv.s3;
      adv.s1 = !vld_ff[1] || adv.s2;
   end

   assign adv_vec   = adv;
   assign req_stall = !adv.s1;
   assign rsp_valid = vld_ff[7];
   assign acc_in    = req_valid && !req_stall;
   assign acc_out   = rsp_valid && !rsp_stall;

   // advance the valid bits with their items
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv_vec[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 7; k++) begin
            if (adv_vec[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   hslc_hue_wrap u_hue_wrap (
      .clock  (clock),
      .adv    (adv),
      .hue    (req_hue),
      .sector (sector),
      .ramp   (ramp)
   );

   hslc_chroma u_chroma (
      .clock      (clock),
      .adv        (adv),
      .saturation (req_saturation),
      .lightness  (req_lightness),
      .alpha      (req_alpha),
      .chroma     (chroma),
      .offset     (offset),
      .opacity    (opacity4)
   );

   hslc_channel u_channel (
      .clock      (clock),
      .adv        (adv),
      .sector     (sector),
      .ramp       (ramp),
      .chroma     (chroma),
      .offset     (offset),
      .opacity_in (opacity4),
      .red        (rsp_red),
      .green      (rsp_green),
      .blue       (rsp_blue),
      .opacity    (rsp_opacity)
   );

   // items in flight and the handshakes that move them
   assign n_vld     = 4'($countones(vld_ff));
   assign no_hs     = !acc_in && !acc_out;
   assign in_only   = acc_in && !acc_out;
   assign full_wait = (&vld_ff) && rsp_stall;

   // input backs up only when every stage holds an item and the output waits
   `HSLC_ASSERT_ALWAYS(a_stall_only_full, !req_stall || full_wait, "input stalled with room left")

   // items in flight change only by an accept or a delivery
   `HSLC_ASSERT_NEXT(a_count_hold, no_hs, n_vld == $past(n_vld), "count changed, no handshake")

   // one accept and no delivery adds exactly one item
   `HSLC_ASSERT_NEXT(a_count_grow, in_only, n_vld == $past(n_vld) + 4'd1, "accepted item lost")

endmodule

### hw/rtl/hslc_hue_wrap.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslc_hue_wrap
// Stages 1-4: wrap the hue into one turn, pick the sector and the distance
// used for the secondary component.
// ---------------------------------------------------------------------------
module hslc_hue_wrap
   import hslc_pkg::*;
(
   input  logic              clock,
   input  pipe_en_type       adv,
   input  logic [HUE_W-1:0]  hue,
   output sector_type        sector,
   output logic [T_W-1:0]    ramp
);

   logic [U_W-1:0]             u_in, u_ff, u2_ff;
   logic [U_W+RECIP_W-1:0]     q_prod;
   logic [Q_W-1:0]             q_in, q_ff;
   logic [U_W-1:0]             q_turns, r0;
   logic [HW_W-1:0]            hw_in, hw_ff;
   logic [HW_W-1:0]            sec_base, rem_w;
   logic [T_W-1:0]             rem;
   sector_type                 sec_in, sec_ff;
   logic [T_W-1:0]             ramp_in, ramp_ff;
   logic                       odd;

   // stage 1: shift hue into the non-negative range
   assign u_in = U_W'({hue[HUE_W-1], hue}) + U_W'(HUE_OFFSET);

   // stage 2: estimate the number of whole turns
   assign q_prod = U_W'(u_ff) * RECIP_W'(RECIP);
   assign q_in   = q_prod[RECIP_SHIFT +: Q_W];

   // stage 3: remainder, corrected once for a low estimate
   assign q_turns = U_W'(q_ff * U_W'(FULL_TURN));
   assign r0      = u2_ff - q_turns;
   assign hw_in   = (r0 >= U_W'(FULL_TURN)) ? HW_W'(r0 - U_W'(FULL_TURN))
                                            : HW_W'(r0);

   // stage 4: sector and distance into it, mirrored in odd sectors
   always_comb begin
      priority if (hw_ff >= HW_W'(5 * SECTOR_LEN)) begin
         sec_in   = SEC_RB;
         sec_base = HW_W'(5 * SECTOR_LEN);
      end else if (hw_ff >= HW_W'(4 * SECTOR_LEN)) begin
         sec_in   = SEC_BR;
         sec_base = HW_W'(4 * SECTOR_LEN);
      end else if (hw_ff >= HW_W'(3 * SECTOR_LEN)) begin
         sec_in   = SEC_BG;
         sec_base = HW_W'(3 * SECTOR_LEN);
      end else if (hw_ff >= HW_W'(2 * SECTOR_LEN)) begin
         sec_in   = SEC_GB;
         sec_base = HW_W'(2 * SECTOR_LEN);
      end else if (hw_ff >= HW_W'(SECTOR_LEN)) begin
         sec_in   = SEC_GR;
         sec_base = HW_W'(SECTOR_LEN);
      end else begin
         sec_in   = SEC_RG;
         sec_base = '0;
      end
   end

   assign rem_w   = hw_ff - sec_base;
   assign rem     = rem_w[T_W-1:0];
   assign odd     = (sec_in == SEC_GR) || (sec_in == SEC_BG) || (sec_in == SEC_RB);
   assign ramp_in = odd ? T_W'(T_W'(SECTOR_LEN) - rem) : rem;

   // advance the stage registers
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         u_ff <= u_in;
      end
      if (adv.s2) begin
         q_ff  <= q_in;
         u2_ff <= u_ff;
      end
      if (adv.s3) begin
         hw_ff <= hw_in;
      end
      if (adv.s4) begin
         sec_ff  <= sec_in;
         ramp_ff <= ramp_in;
      end
   end

   assign sector = sec_ff;
   assign ramp   = ramp_ff;

endmodule

### hw/rtl/hslc_chroma.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslc_chroma
// Stages 1-4: clamp the fractions, form chroma, the offset term and the
// opacity byte.
// ---------------------------------------------------------------------------
module hslc_chroma
   import hslc_pkg::*;
(
   input  logic                clock,
   input  pipe_en_type         adv,
   input  logic [FIELD_W-1:0]  saturation,
   input  logic [FIELD_W-1:0]  lightness,
   input  logic [FIELD_W-1:0]  alpha,
   output logic [C2_W-1:0]     chroma,
   output logic [A_W-1:0]      offset,
   output logic [BYTE_W-1:0]   opacity
);

   logic [CL_W-1:0]        sat_ff, lig_ff, alp_ff, lig2_ff;
   logic [CL_W:0]          twice;
   logic [CL_W-1:0]        dev, omd;
   logic [C2_W-1:0]        c2_in, c2_ff, c2_3_ff, c2_4_ff;
   logic [CL_W+BYTE_W-1:0] alp_prod;
   logic [BYTE_W-1:0]      opa_in, opa2_ff, opa3_ff, opa4_ff;
   logic [A_W-1:0]         a_in, a_ff, a4_ff;

   // limit a signed fraction to 0..1
   function automatic logic [CL_W-1:0] clamp_unit(input logic [FIELD_W-1:0] v);
      logic signed [FIELD_W-1:0] sv;
      sv = signed'(v);
      if (sv < 0) begin
         return '0;
      end else if (sv > signed'(FIELD_W'(ONE))) begin
         return CL_W'(ONE);
      end else begin
         return v[CL_W-1:0];
      end
   endfunction

   // stage 2: chroma = (1 - |2l - 1|) * s, opacity byte
   assign twice    = {lig_ff, 1'b0};
   assign dev      = (twice >= (CL_W+1)'(ONE)) ? CL_W'(twice - (CL_W+1)'(ONE))
                                               : CL_W'((CL_W+1)'(ONE) - twice);
   assign omd      = CL_W'(ONE) - dev;
   assign c2_in    = C2_W'(C2_W'(omd) * C2_W'(sat_ff));
   assign alp_prod = (CL_W+BYTE_W)'(alp_ff) * (CL_W+BYTE_W)'(255);
   assign opa_in   = alp_prod[FRAC_BITS +: BYTE_W];

   // stage 3: offset term 2*l*ONE - chroma, never negative
   assign a_in = (A_W'(lig2_ff) << (FRAC_BITS + 1)) - A_W'(c2_ff);

   // advance the stage registers
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         sat_ff <= clamp_unit(saturation);
         lig_ff <= clamp_unit(lightness);
         alp_ff <= clamp_unit(alpha);
      end
      if (adv.s2) begin
         c2_ff   <= c2_in;
         lig2_ff <= lig_ff;
         opa2_ff <= opa_in;
      end
      if (adv.s3) begin
         a_ff    <= a_in;
         c2_3_ff <= c2_ff;
         opa3_ff <= opa2_ff;
      end
      if (adv.s4) begin
         a4_ff   <= a_ff;
         c2_4_ff <= c2_3_ff;
         opa4_ff <= opa3_ff;
      end
   end

   assign chroma  = c2_4_ff;
   assign offset  = a4_ff;
   assign opacity = opa4_ff;

endmodule

### hw/rtl/hslc_channel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslc_channel
// Stages 5-7: build the channel numerators, place them by sector and scale
// each to a byte. Stage 7 is the output register.
// ---------------------------------------------------------------------------
module hslc_channel
   import hslc_pkg::*;
(
   input  logic               clock,
   input  pipe_en_type        adv,
   input  sector_type         sector,
   input  logic [T_W-1:0]     ramp,
   input  logic [C2_W-1:0]    chroma,
   input  logic [A_W-1:0]     offset,
   input  logic [BYTE_W-1:0]  opacity_in,
   output logic [BYTE_W-1:0]  red,
   output logic [BYTE_W-1:0]  green,
   output logic [BYTE_W-1:0]  blue,
   output logic [BYTE_W-1:0]  opacity
);

   logic [N_W-1:0]    p_in, p_ff, base_in, base_ff, full_in, full_ff;
   logic [N_W-1:0]    sum_a;
   sector_type        sec5_ff;
   logic [BYTE_W-1:0] opa5_ff, opa6_ff, opa7_ff;
   logic [N_W-1:0]    nx;
   logic [N_W-1:0]    nr_in, ng_in, nb_in, nr_ff, ng_ff, nb_ff;
   logic [BYTE_W-1:0] red_ff, green_ff, blue_ff;

   // floor(255 * n / denominator) as a multiply by 17 and a shift
   function automatic logic [BYTE_W-1:0] to_byte(input logic [N_W-1:0] n);
      logic [SCALED_W-1:0] prod;
      prod = SCALED_W'(n) * SCALED_W'(SCALE_MUL);
      return prod[SCALE_SHIFT +: BYTE_W];
   endfunction

   // stage 5: secondary product, offset-only and chroma numerators
   assign p_in    = N_W'(N_W'(chroma) * N_W'(ramp));
   assign base_in = N_W'(N_W'(offset) * N_W'(SECTOR_LEN));
   assign sum_a   = N_W'(offset) + (N_W'(chroma) << 1);
   assign full_in = N_W'(sum_a * N_W'(SECTOR_LEN));

   // stage 6: place chroma and secondary on the channels
   assign nx = base_ff + (p_ff << 1);

   always_comb begin
      unique case (sec5_ff)
         SEC_RG: begin
            nr_in = full_ff;
            ng_in = nx;
            nb_in = base_ff;
         end
         SEC_GR: begin
            nr_in = nx;
            ng_in = full_ff;
            nb_in = base_ff;
         end
         SEC_GB: begin
            nr_in = base_ff;
            ng_in = full_ff;
            nb_in = nx;
         end
         SEC_BG: begin
            nr_in = base_ff;
            ng_in = nx;
            nb_in = full_ff;
         end
         SEC_BR: begin
            nr_in = nx;
            ng_in = base_ff;
            nb_in = full_ff;
         end
         default: begin
            nr_in = full_ff;
            ng_in = base_ff;
            nb_in = nx;
         end
      endcase
   end

   // advance the stage registers
   always_ff @(posedge clock) begin
      if (adv.s5) begin
         p_ff    <= p_in;
         base_ff <= base_in;
         full_ff <= full_in;
         sec5_ff <= sector;
         opa5_ff <= opacity_in;
      end
      if (adv.s6) begin
         nr_ff   <= nr_in;
         ng_ff   <= ng_in;
         nb_ff   <= nb_in;
         opa6_ff <= opa5_ff;
      end
      if (adv.s7) begin
         red_ff   <= to_byte(nr_ff);
         green_ff <= to_byte(ng_ff);
         blue_ff  <= to_byte(nb_ff);
         opa7_ff  <= opa6_ff;
      end
   end

   assign red     = red_ff;
   assign green   = green_ff;
   assign blue    = blue_ff;
   assign opacity = opa7_ff;

endmodule

### bench/hsl_to_rgb_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl_to_rgb_checker
// Watches both channels of the HSL to RGB converter. Converts every accepted
// item in exact integer arithmetic and compares each result, field by
// field and in order, with the oldest converted color still waiting.
// ---------------------------------------------------------------------------
module hsl_to_rgb_checker
   import hslc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [HUE_W-1:0]   req_hue,
   input  logic [FIELD_W-1:0] req_saturation,
   input  logic [FIELD_W-1:0] req_lightness,
   input  logic [FIELD_W-1:0] req_alpha,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [BYTE_W-1:0]  rsp_red,
   input  logic [BYTE_W-1:0]  rsp_green,
   input  logic [BYTE_W-1:0]  rsp_blue,
   input  logic [BYTE_W-1:0]  rsp_opacity,
   output int                 mismatches,
   output int                 outstanding
);

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] opacity;
   } rgba_type;

   rgba_type rgba_pending[$];

   // saturate a signed fraction field to 0..ONE
   function automatic longint clamp_fraction(logic [FIELD_W-1:0] raw);
      longint v;
      v = $signed(raw);
      if (v < 0)
         v = 0;
      else if (v > ONE)
         v = ONE;
      return v;
   endfunction

   // exact conversion: channel numerators over 2 * ONE^2 * SECTOR_LEN
   function automatic rgba_type convert_hsl_to_rgba(logic [HUE_W-1:0]   hue_raw,
                                                    logic [FIELD_W-1:0] sat_raw,
                                                    logic [FIELD_W-1:0] lig_raw,
                                                    logic [FIELD_W-1:0] alp_raw);
      longint          hue_val;
      longint          wrapped;
      longint          sector_idx;
      longint          pos;
      longint          ramp;
      longint          dev;
      longint          sat;
      longint          lig;
      longint          alp;
      longint unsigned chroma2;
      longint unsigned n_c;
      longint unsigned n_x;
      longint unsigned n_m;
      longint unsigned den;
      longint unsigned r;
      longint unsigned g;
      longint unsigned b;
      sector_type      sec;
      rgba_type        res;
      hue_val = $signed(hue_raw);
      sat     = clamp_fraction(sat_raw);
      lig     = clamp_fraction(lig_raw);
      alp     = clamp_fraction(alp_raw);

      // wrap hue into one turn, never negative
      wrapped = hue_val % FULL_TURN;
      if (wrapped < 0)
         wrapped = wrapped + FULL_TURN;
      sector_idx = wrapped / SECTOR_LEN;
      pos        = wrapped % SECTOR_LEN;
      ramp       = sector_idx[0] ? SECTOR_LEN - pos : pos;
      sec        = sector_type'(sector_idx[2:0]);

      dev = 2 * lig - ONE;
      if (dev < 0)
         dev = -dev;
      chroma2 = (ONE - dev) * sat;

      n_c = chroma2 * 64'd2 * SECTOR_LEN;
      n_x = chroma2 * 64'd2 * ramp;
      n_m = lig * 64'd2 * ONE * SECTOR_LEN - chroma2 * SECTOR_LEN;
      den = 64'd2 * ONE * ONE * SECTOR_LEN;

      // place chroma and secondary on the channels of this sector
      r = 0;
      g = 0;
      b = 0;
      case (sec)
         SEC_RG: begin r = n_c; g = n_x; end
         SEC_GR: begin r = n_x; g = n_c; end
         SEC_GB: begin g = n_c; b = n_x; end
         SEC_BG: begin g = n_x; b = n_c; end
         SEC_BR: begin r = n_x; b = n_c; end
         default: begin r = n_c; b = n_x; end
      endcase

      res.red     = BYTE_W'((r + n_m) * 64'd255 / den);
      res.green   = BYTE_W'((g + n_m) * 64'd255 / den);
      res.blue    = BYTE_W'((b + n_m) * 64'd255 / den);
      res.opacity = BYTE_W'(alp * 64'd255 / ONE);
      return res;
   endfunction

   // retire results against the oldest color, then queue the new item
   always @(posedge clock) begin
      rgba_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rgba_pending.size() == 0) begin
               $error("unexpected result: red %0d green %0d blue %0d opacity %0d",
                      rsp_red, rsp_green, rsp_blue, rsp_opacity);
               mismatches++;
            end else begin
               want = rgba_pending.pop_front();
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_red);
                  mismatches++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_green);
                  mismatches++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
                  mismatches++;
               end
               if (rsp_opacity !== want.opacity) begin
                  $error("opacity: expected %0d, got %0d", want.opacity, rsp_opacity);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            rgba_pending = {rgba_pending,
                            convert_hsl_to_rgba(req_hue, req_saturation,
                                                req_lightness, req_alpha)};
      end
      outstanding = rgba_pending.size();
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the HSL to RGB converter with directed corner colors and then
// random colors under phases of sender gaps and receiver stalls; the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
   import hslc_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [HUE_W-1:0]   req_hue;
   logic [FIELD_W-1:0] req_saturation;
   logic [FIELD_W-1:0] req_lightness;
   logic [FIELD_W-1:0] req_alpha;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [BYTE_W-1:0]  rsp_red;
   logic [BYTE_W-1:0]  rsp_green;
   logic [BYTE_W-1:0]  rsp_blue;
   logic [BYTE_W-1:0]  rsp_opacity;
   int                 mismatches;
   int                 outstanding;
   int                 send_idle_pct;
   int                 recv_stall_pct;

   hsl_to_rgb_converter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_opacity    (rsp_opacity)
   );

   hsl_to_rgb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_opacity    (rsp_opacity),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // offer one item after a random gap; return at the negedge after acceptance
   task automatic send_color(int hue, int sat, int lig, int alp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= HUE_W'(hue);
      req_saturation <= FIELD_W'(sat);
      req_lightness  <= FIELD_W'(lig);
      req_alpha      <= FIELD_W'(alp);
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // hold the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // hue mix: full range, a few turns around zero, sector edges, whole turns, values within one turn
   function automatic int pick_hue();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $signed($urandom_range(0, 6 * FULL_TURN)) - 3 * FULL_TURN;
         2: return $urandom_range(0, 5) * SECTOR_LEN + $urandom_range(0, 2) - 1
                   + ($signed($urandom_range(0, 20)) - 10) * FULL_TURN;
         3: return ($signed($urandom_range(0, 700)) - 350) * FULL_TURN;
         default: return $urandom_range(0, FULL_TURN - 1);
      endcase
   endfunction

   // fraction mix: mostly in range, some edges, some full range
   function automatic int pick_level();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return ONE + $urandom_range(0, 2) - 1;
         2: return $urandom_range(0, 2) - 1;
         3: return ONE / 2 + $urandom_range(0, 4) - 2;
         default: return $signed($urandom_range(0, ONE + 200)) - 100;
      endcase
   endfunction

   task automatic run_phase(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count)
         send_color(pick_hue(), pick_level(), pick_level(), pick_level());
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_lightness  = '0;
      req_alpha      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sector starts and ends at full saturation, half lightness
      send_color(0, ONE, ONE / 2, ONE);
      send_color(SECTOR_LEN, ONE, ONE / 2, ONE);
      send_color(2 * SECTOR_LEN, ONE, ONE / 2, ONE);
      send_color(3 * SECTOR_LEN, ONE, ONE / 2, ONE);
      send_color(4 * SECTOR_LEN, ONE, ONE / 2, ONE);
      send_color(5 * SECTOR_LEN, ONE, ONE / 2, ONE);
      send_color(SECTOR_LEN - 1, ONE, ONE / 2, ONE);
      send_color(FULL_TURN - 1, ONE, ONE / 2, ONE);
      // hue wrap: a whole turn, negative hue, field extremes
      send_color(FULL_TURN, ONE, ONE / 2, ONE);
      send_color(-1, ONE, ONE / 2, ONE);
      send_color(-FULL_TURN, ONE, ONE / 2, ONE);
      send_color(-8388608, 32767, ONE / 2, 32767);
      send_color(8388607, -32768, -32768, -32768);
      // fractions just outside and at the range ends, then mixed values
      send_color(1000, ONE + 1, ONE + 1, ONE + 1);
      send_color(1000, -1, -1, -1);
      send_color(1000, ONE, 0, 0);
      send_color(1000, ONE, ONE, ONE);
      send_color(1000, 0, ONE / 2, ONE / 2);
      send_color(3 * SECTOR_LEN / 2, ONE, ONE / 4, ONE - 1);
      send_color(-1000, 32767, 32767, 32767);
      send_color(3 * SECTOR_LEN + 17, 2000, 3000, 1);
      drain();

      run_phase(200, 0, 0);
      run_phase(150, 88, 0);
      run_phase(150, 0, 88);
      run_phase(200, 19, 19);
      run_phase(80, 0, 0);

      // let the pipeline settle
      repeat (12) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
